/* hdl/tdpf_pkg.sv */
// Package with the constants, register indexes and sequencer state type of the firing block.
`timescale 1ns / 1ps

package tdpf_pkg;

    localparam int TIMER_BITS  = 18;
    localparam int HALF_BITS   = 16;
    localparam int WIDTH_BITS  = 16;
    localparam int GAP_BITS    = 16;
    localparam int GUARD_BITS  = 16;
    localparam int LOCK_BITS   = 18;
    localparam int SAMPLE_BITS = 10;
    localparam int PROD_BITS   = HALF_BITS + SAMPLE_BITS;
    localparam int CFG_BITS    = 18;
    localparam int CFG_IDX_BITS = 3;
    localparam int S_DATA_BITS = 16;
    localparam int M_DATA_BITS = 8;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    localparam logic [PROD_BITS-1:0] ANGLE_FULL_SCALE = PROD_BITS'(1023);

    localparam logic [HALF_BITS-1:0]  HALF_PERIOD_RST = HALF_BITS'(8333);
    localparam logic [WIDTH_BITS-1:0] PULSE_WIDTH_RST = WIDTH_BITS'(583);
    localparam logic [GAP_BITS-1:0]   PULSE_GAP_RST   = GAP_BITS'(2777);
    localparam logic [GUARD_BITS-1:0] GUARD_RST       = GUARD_BITS'(500);
    localparam logic [LOCK_BITS-1:0]  LOCKOUT_RST     = LOCK_BITS'(12500);

    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_PERIOD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_WIDTH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_GAP   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GUARD       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOCKOUT     = 3'd4;

    typedef enum logic [1:0] {
        PH_DELAY  = 2'd0,
        PH_PULSE1 = 2'd1,
        PH_GAP    = 2'd2,
        PH_PULSE2 = 2'd3
    } phase_t;

endpackage

/* hdl/thyristor_double_pulse_firing.sv */
// Top level of the double-pulse thyristor firing controller with phase-angle delay.
`timescale 1ns / 1ps

// The block takes one request per microsecond tick on the s_ channel. Each request carries
// a zero-crossing edge flag and a 10-bit firing-angle sample; it returns exactly one result
// on the m_ channel holding the gate level and the busy flag after that tick.
// A crossing is taken only when more than lockout_us ticks have passed since the last one
// taken. It arms the sequencer, which waits half_period_us * sample / 1023 ticks (clamped to
// half_period_us - guard_us), drives a gate pulse of pulse_width_us, and drives a second
// pulse pulse_gap_us after the start of the first one before it disarms.
// Timing registers are written through the cfg_ port and should change only while idle.
// A new request is taken every cycle while the output is not stalled.
// The path runs through an input register, a multiply stage, a quotient estimate stage, a
// correction and clamp stage, and the sequencer stage that feeds the output register.
// All stages move together: when a result waits and m_tready is low, s_tready drops and
// the whole pipeline holds. Sequencer state advances only when a result is written.
// A synchronous reset (aresetn low) empties the pipeline, disarms the sequencer, clears
// both timers and the gate level, and restores the register defaults.
module thyristor_double_pulse_firing
    import tdpf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // Fields from bit 0 up: crossing_edge [0], angle_sample [10:1], zero fill [15:11].
    input  logic [S_DATA_BITS-1:0]  s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // Fields from bit 0 up: gate_drive [0], busy_res [1], zero fill [7:2].
    output logic [M_DATA_BITS-1:0]  m_tdata,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [CFG_BITS-1:0]     cfg_wdata
);

    logic [HALF_BITS-1:0]  half_period_reg;
    logic [WIDTH_BITS-1:0] pulse_width_reg;
    logic [GAP_BITS-1:0]   pulse_gap_reg;
    logic [GUARD_BITS-1:0] guard_reg;
    logic [LOCK_BITS-1:0]  lockout_reg;

    logic                   advance;

    logic                   v1_reg;
    logic                   edge1_reg;
    logic [SAMPLE_BITS-1:0] sample1_reg;

    logic                   v2_reg;
    logic                   edge2_reg;
    logic [PROD_BITS-1:0]   prod2_reg;

    logic                   v3_reg;
    logic                   edge3_reg;
    logic [PROD_BITS-1:0]   prod3_reg;
    logic [HALF_BITS-1:0]   qest3_reg;

    logic                   v4_reg;
    logic                   edge4_reg;
    logic [HALF_BITS-1:0]   delay4_reg;

    logic [PROD_BITS-1:0]   prod_next;
    logic [PROD_BITS-1:0]   est_sum;
    logic [HALF_BITS-1:0]   qest_next;
    logic [PROD_BITS:0]     remainder;
    logic [HALF_BITS-1:0]   quotient;
    logic [HALF_BITS-1:0]   delay_limit;
    logic [HALF_BITS-1:0]   delay_next;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic [TIMER_BITS-1:0]  step_timer_reg;
    logic [TIMER_BITS-1:0]  step_timer_next;
    logic [TIMER_BITS-1:0]  cross_timer_reg;
    logic [TIMER_BITS-1:0]  cross_timer_next;
    logic                   gate_reg;
    logic                   gate_next;

    logic [TIMER_BITS-1:0]  step_adv;
    logic [TIMER_BITS-1:0]  cross_adv;
    logic                   take_crossing;
    logic [TIMER_BITS-1:0]  step_base;
    logic                   armed_base;
    phase_t                 phase_base;

    logic                   m_tvalid_reg;
    logic [M_DATA_BITS-1:0] m_tdata_reg;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RST;
            pulse_width_reg <= PULSE_WIDTH_RST;
            pulse_gap_reg   <= PULSE_GAP_RST;
            guard_reg       <= GUARD_RST;
            lockout_reg     <= LOCKOUT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_HALF_PERIOD: half_period_reg <= cfg_wdata[HALF_BITS-1:0];
                REG_PULSE_WIDTH: pulse_width_reg <= cfg_wdata[WIDTH_BITS-1:0];
                REG_PULSE_GAP:   pulse_gap_reg   <= cfg_wdata[GAP_BITS-1:0];
                REG_GUARD:       guard_reg       <= cfg_wdata[GUARD_BITS-1:0];
                REG_LOCKOUT:     lockout_reg     <= cfg_wdata[LOCK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The quotient estimate by 1023 never exceeds the true quotient and is short by at most one.
    assign prod_next = PROD_BITS'(half_period_reg) * PROD_BITS'(sample1_reg);
    assign est_sum   = prod2_reg + (prod2_reg >> 10) + (prod2_reg >> 20);
    assign qest_next = est_sum[PROD_BITS-1:10];

    assign remainder = {1'b0, prod3_reg} - {1'b0, qest3_reg, 10'b0} + (PROD_BITS+1)'(qest3_reg);
    assign quotient  = (remainder >= (PROD_BITS+1)'(ANGLE_FULL_SCALE)) ? qest3_reg + 1'b1
                                                                         : qest3_reg;
    assign delay_limit = (guard_reg >= half_period_reg) ? '0 : half_period_reg - guard_reg;
    assign delay_next  = (quotient > delay_limit) ? delay_limit : quotient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            edge1_reg   <= s_tdata[0];
            sample1_reg <= s_tdata[SAMPLE_BITS:1];
            edge2_reg   <= edge1_reg;
            prod2_reg   <= prod_next;
            edge3_reg   <= edge2_reg;
            prod3_reg   <= prod2_reg;
            qest3_reg   <= qest_next;
            edge4_reg   <= edge3_reg;
            delay4_reg  <= delay_next;
        end
    end

    assign step_adv  = (step_timer_reg == TIMER_MAX) ? TIMER_MAX : step_timer_reg + 1'b1;
    assign cross_adv = (cross_timer_reg == TIMER_MAX) ? TIMER_MAX : cross_timer_reg + 1'b1;
    assign take_crossing = edge4_reg && (cross_adv > lockout_reg);
    assign step_base  = take_crossing ? '0 : step_adv;
    assign armed_base = take_crossing ? 1'b1 : armed_reg;
    assign phase_base = take_crossing ? PH_DELAY : phase_reg;
    assign cross_timer_next = take_crossing ? '0 : cross_adv;

    always_comb begin
        phase_next = phase_base;
        if (armed_base) begin
            case (phase_base)
                PH_DELAY: begin
                    if (step_base > TIMER_BITS'(delay4_reg)) phase_next = PH_PULSE1;
                end
                PH_PULSE1: begin
                    if (step_base > TIMER_BITS'(pulse_width_reg)) phase_next = PH_GAP;
                end
                PH_GAP: begin
                    if (step_base > TIMER_BITS'(pulse_gap_reg)) phase_next = PH_PULSE2;
                end
                PH_PULSE2: begin
                    if (step_base > TIMER_BITS'(pulse_width_reg)) phase_next = PH_DELAY;
                end
                default: phase_next = PH_DELAY;
            endcase
        end
    end

    always_comb begin
        step_timer_next = step_base;
        armed_next      = armed_base;
        gate_next       = gate_reg;
        if (armed_base && (phase_next != phase_base)) begin
            case (phase_next)
                PH_PULSE1: begin
                    gate_next       = 1'b1;
                    step_timer_next = '0;
                end
                PH_GAP: begin
                    gate_next = 1'b0;
                end
                PH_PULSE2: begin
                    gate_next       = 1'b1;
                    step_timer_next = '0;
                end
                PH_DELAY: begin
                    gate_next  = 1'b0;
                    armed_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_DELAY;
            armed_reg       <= 1'b0;
            step_timer_reg  <= '0;
            cross_timer_reg <= '0;
            gate_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= v4_reg;
            if (v4_reg) begin
                phase_reg       <= phase_next;
                armed_reg       <= armed_next;
                step_timer_reg  <= step_timer_next;
                cross_timer_reg <= cross_timer_next;
                gate_reg        <= gate_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && v4_reg) begin
            m_tdata_reg <= {{(M_DATA_BITS-2){1'b0}}, armed_next, gate_next};
        end
    end

`ifndef NO_ASSERTIONS
    a_gate_needs_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        gate_reg |-> armed_reg)
        else $error("Gate is high while the sequencer is disarmed.");

    a_phase_needs_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_DELAY) |-> armed_reg)
        else $error("Sequencer left the delay phase while disarmed.");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(step_timer_reg) && $stable(cross_timer_reg)))
        else $error("Timers moved while the pipeline was stalled.");

    a_crossing_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && v4_reg && take_crossing) |=> (cross_timer_reg == '0 && armed_reg))
        else $error("Accepted crossing did not restart the crossing timer and arm.");
`endif

endmodule
